// File: rtl/core/qvr_pkg.sv
// ============================================================================
// qvr_pkg: shared types and constants for the quaternion vector rotator
// Payload structs, quaternion and intermediate types, register map and
// fixed-point constants.
// ============================================================================
`default_nettype none

package qvr_pkg;

  localparam int FRAC_BITS = 15;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [1:0] REG_QUAT_X = 2'd0;
  localparam logic [1:0] REG_QUAT_Y = 2'd1;
  localparam logic [1:0] REG_QUAT_Z = 2'd2;
  localparam logic [1:0] REG_QUAT_W = 2'd3;

  localparam logic signed [15:0] QUAT_W_RESET = 16'sh7FFF;
  localparam logic signed [15:0] MAX16        = 16'sh7FFF;
  localparam logic signed [15:0] MIN16        = 16'sh8000;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [15:0] w;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic               clipped;
  } out_item_t;

  typedef struct packed {
    logic signed [17:0] tx;
    logic signed [17:0] ty;
    logic signed [17:0] tz;
    logic signed [17:0] tw;
  } tvec_t;

endpackage

`default_nettype wire

// File: rtl/core/qvr_cfg.sv
// ============================================================================
// qvr_cfg: quaternion register file
// APB-style register port holding the four Q1.15 quaternion components.
// ============================================================================
`default_nettype none

module qvr_cfg import qvr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output quat_t                  quat
);

  quat_t quat_r;
  quat_t quat_nxt;
  logic  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign quat   = quat_r;

  always_comb begin
    quat_nxt = quat_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_QUAT_X: quat_nxt.x = pwdata[15:0];
        REG_QUAT_Y: quat_nxt.y = pwdata[15:0];
        REG_QUAT_Z: quat_nxt.z = pwdata[15:0];
        REG_QUAT_W: quat_nxt.w = pwdata[15:0];
        default:    quat_nxt   = quat_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_QUAT_X: prdata = {16'd0, quat_r.x};
      REG_QUAT_Y: prdata = {16'd0, quat_r.y};
      REG_QUAT_Z: prdata = {16'd0, quat_r.z};
      REG_QUAT_W: prdata = {16'd0, quat_r.w};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_r.x <= '0;
      quat_r.y <= '0;
      quat_r.z <= '0;
      quat_r.w <= QUAT_W_RESET;
    end else begin
      quat_r <= quat_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/qvr_conj_mul.sv
// ============================================================================
// qvr_conj_mul: first Hamilton product, t = (v,0) * conj(q)
// Stage one registers twelve 16x16 products, stage two sums, rounds to
// 15 fractional bits and keeps t at 18 bits.
// ============================================================================
`default_nettype none

module qvr_conj_mul import qvr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire quat_t    quat,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output tvec_t         out_data
);

  logic signed [15:0] qx, qy, qz, qw, vx, vy, vz;

  logic               v1_r, v2_r;
  logic               rdy1, rdy2;
  logic signed [31:0] p_vzqy_r, p_vyqz_r, p_qwvx_r;
  logic signed [31:0] p_vxqz_r, p_vzqx_r, p_qwvy_r;
  logic signed [31:0] p_vyqx_r, p_vxqy_r, p_qwvz_r;
  logic signed [31:0] p_vxqx_r, p_vyqy_r, p_vzqz_r;
  logic signed [33:0] sx, sy, sz, sw;
  tvec_t              t_r;

  assign qx = quat.x;
  assign qy = quat.y;
  assign qz = quat.z;
  assign qw = quat.w;
  assign vx = in_data.vec_x;
  assign vy = in_data.vec_y;
  assign vz = in_data.vec_z;

  assign rdy2      = !v2_r || out_ready;
  assign rdy1      = !v1_r || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v2_r;
  assign out_data  = t_r;

  assign sx = 34'(p_vzqy_r) - 34'(p_vyqz_r) + 34'(p_qwvx_r) + 34'sd16384;
  assign sy = 34'(p_vxqz_r) - 34'(p_vzqx_r) + 34'(p_qwvy_r) + 34'sd16384;
  assign sz = 34'(p_vyqx_r) - 34'(p_vxqy_r) + 34'(p_qwvz_r) + 34'sd16384;
  assign sw = 34'(p_vxqx_r) + 34'(p_vyqy_r) + 34'(p_vzqz_r) + 34'sd16384;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      p_vzqy_r <= 32'(vz) * 32'(qy);
      p_vyqz_r <= 32'(vy) * 32'(qz);
      p_qwvx_r <= 32'(qw) * 32'(vx);
      p_vxqz_r <= 32'(vx) * 32'(qz);
      p_vzqx_r <= 32'(vz) * 32'(qx);
      p_qwvy_r <= 32'(qw) * 32'(vy);
      p_vyqx_r <= 32'(vy) * 32'(qx);
      p_vxqy_r <= 32'(vx) * 32'(qy);
      p_qwvz_r <= 32'(qw) * 32'(vz);
      p_vxqx_r <= 32'(vx) * 32'(qx);
      p_vyqy_r <= 32'(vy) * 32'(qy);
      p_vzqz_r <= 32'(vz) * 32'(qz);
    end
    if (rdy2 && v1_r) begin
      t_r.tx <= sx[FRAC_BITS+17:FRAC_BITS];
      t_r.ty <= sy[FRAC_BITS+17:FRAC_BITS];
      t_r.tz <= sz[FRAC_BITS+17:FRAC_BITS];
      t_r.tw <= sw[FRAC_BITS+17:FRAC_BITS];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/qvr_quat_mul.sv
// ============================================================================
// qvr_quat_mul: second Hamilton product, r = q * t
// Stage three registers twelve 16x18 products, stage four sums, rounds,
// saturates to 16 bits and drives the result register.
// ============================================================================
`default_nettype none

module qvr_quat_mul import qvr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire quat_t quat,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire tvec_t in_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_item_t  out_data
);

  logic signed [15:0] qx, qy, qz, qw;
  logic signed [17:0] tx, ty, tz, tw;

  logic               v3_r, v4_r;
  logic               rdy3, rdy4;
  logic signed [33:0] p_qytz_r, p_qzty_r, p_qwtx_r, p_twqx_r;
  logic signed [33:0] p_qztx_r, p_qxtz_r, p_qwty_r, p_twqy_r;
  logic signed [33:0] p_qxty_r, p_qytx_r, p_qwtz_r, p_twqz_r;
  logic signed [35:0] sx, sy, sz;
  logic signed [20:0] rx, ry, rz;
  logic signed [15:0] cx, cy, cz;
  logic               clx, cly, clz;
  out_item_t          res_r;

  assign qx = quat.x;
  assign qy = quat.y;
  assign qz = quat.z;
  assign qw = quat.w;
  assign tx = in_data.tx;
  assign ty = in_data.ty;
  assign tz = in_data.tz;
  assign tw = in_data.tw;

  assign rdy4      = !v4_r || out_ready;
  assign rdy3      = !v3_r || rdy4;
  assign in_ready  = rdy3;
  assign out_valid = v4_r;
  assign out_data  = res_r;

  assign sx = 36'(p_qytz_r) - 36'(p_qzty_r) + 36'(p_qwtx_r) + 36'(p_twqx_r) + 36'sd16384;
  assign sy = 36'(p_qztx_r) - 36'(p_qxtz_r) + 36'(p_qwty_r) + 36'(p_twqy_r) + 36'sd16384;
  assign sz = 36'(p_qxty_r) - 36'(p_qytx_r) + 36'(p_qwtz_r) + 36'(p_twqz_r) + 36'sd16384;

  assign rx = sx[FRAC_BITS+20:FRAC_BITS];
  assign ry = sy[FRAC_BITS+20:FRAC_BITS];
  assign rz = sz[FRAC_BITS+20:FRAC_BITS];

  always_comb begin
    clx = 1'b1;
    cly = 1'b1;
    clz = 1'b1;
    if (rx > 21'(MAX16)) begin
      cx = MAX16;
    end else if (rx < 21'(MIN16)) begin
      cx = MIN16;
    end else begin
      cx  = rx[15:0];
      clx = 1'b0;
    end
    if (ry > 21'(MAX16)) begin
      cy = MAX16;
    end else if (ry < 21'(MIN16)) begin
      cy = MIN16;
    end else begin
      cy  = ry[15:0];
      cly = 1'b0;
    end
    if (rz > 21'(MAX16)) begin
      cz = MAX16;
    end else if (rz < 21'(MIN16)) begin
      cz = MIN16;
    end else begin
      cz  = rz[15:0];
      clz = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy3) begin
        v3_r <= in_valid;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && in_valid) begin
      p_qytz_r <= 34'(qy) * 34'(tz);
      p_qzty_r <= 34'(qz) * 34'(ty);
      p_qwtx_r <= 34'(qw) * 34'(tx);
      p_twqx_r <= 34'(tw) * 34'(qx);
      p_qztx_r <= 34'(qz) * 34'(tx);
      p_qxtz_r <= 34'(qx) * 34'(tz);
      p_qwty_r <= 34'(qw) * 34'(ty);
      p_twqy_r <= 34'(tw) * 34'(qy);
      p_qxty_r <= 34'(qx) * 34'(ty);
      p_qytx_r <= 34'(qy) * 34'(tx);
      p_qwtz_r <= 34'(qw) * 34'(tz);
      p_twqz_r <= 34'(tw) * 34'(qz);
    end
    if (rdy4 && v3_r) begin
      res_r.rot_x   <= cx;
      res_r.rot_y   <= cy;
      res_r.rot_z   <= cz;
      res_r.clipped <= clx || cly || clz;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/quaternion_vector_rotate_unit.sv
// ============================================================================
// quaternion_vector_rotate_unit: rotates 3-vectors by a configured quaternion
// Computes q * (v,0) * conj(q) in two Hamilton products, each a multiply
// stage and a sum-and-round stage, with rounding and 16-bit saturation.
// Throughput: one vector per cycle while out_stall is low; the four-stage pipeline sets it.
// A stalled output holds its stage; bubbles ahead of it still fill.
// Reset clears all stage valid bits and loads the identity quaternion.
// ============================================================================
`default_nettype none

module quaternion_vector_rotate_unit import qvr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data
);

  quat_t quat;
  logic  in_ready;
  logic  t_valid;
  logic  t_ready;
  tvec_t t_data;

  assign in_stall = !in_ready;

  qvr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .quat    (quat)
  );

  qvr_conj_mul u_conj_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .quat      (quat),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (t_valid),
    .out_ready (t_ready),
    .out_data  (t_data)
  );

  qvr_quat_mul u_quat_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .quat      (quat),
    .in_valid  (t_valid),
    .in_ready  (t_ready),
    .in_data   (t_data),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_data  (out_data)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid && !t_valid)
    else $error("pipeline not empty after reset");

  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (t_valid && !t_ready) |=> (t_valid && $stable(t_data)))
    else $error("intermediate product lost or changed while held");

  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.clipped) |->
      (out_data.rot_x == MAX16 || out_data.rot_x == MIN16 ||
       out_data.rot_y == MAX16 || out_data.rot_y == MIN16 ||
       out_data.rot_z == MAX16 || out_data.rot_z == MIN16))
    else $error("clipped flag set with no component at a rail");

  a_stall_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (!t_valid && !out_valid) |-> !in_stall)
    else $error("input stalled while the pipeline tail is empty");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// ============================================================================
// tb_top: regression bench for quaternion_vector_rotate_unit
// Loads a series of quaternions through the register port, streams vectors
// through the rotator with random gaps and output stalls, and checks every
// result against an independent fixed-point prediction of q * (v,0) * conj(q).
// ============================================================================
`default_nettype none

module tb_top;
  import qvr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  class rotation_scoreboard;
    quat_t     quat;
    out_item_t expected_rotations[$];
    int        failures;

    function new();
      quat     = '{x: 16'sd0, y: 16'sd0, z: 16'sd0, w: QUAT_W_RESET};
      failures = 0;
    endfunction

    function void set_component(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_QUAT_X: quat.x = val;
        REG_QUAT_Y: quat.y = val;
        REG_QUAT_Z: quat.z = val;
        REG_QUAT_W: quat.w = val;
        default: ;
      endcase
    endfunction

    function longint half_up(longint s);
      return (s + 64'sd16384) >>> FRAC_BITS;
    endfunction

    function logic [15:0] clamp16(longint s, ref logic clip);
      if (s > 32767) begin
        clip = 1'b1;
        return MAX16;
      end
      if (s < -32768) begin
        clip = 1'b1;
        return MIN16;
      end
      return s[15:0];
    endfunction

    function out_item_t rotate(in_item_t v);
      longint    qx, qy, qz, qw, vx, vy, vz;
      longint    tx, ty, tz, tw, rx, ry, rz;
      logic      clip;
      out_item_t res;
      qx = $signed(quat.x);
      qy = $signed(quat.y);
      qz = $signed(quat.z);
      qw = $signed(quat.w);
      vx = $signed(v.vec_x);
      vy = $signed(v.vec_y);
      vz = $signed(v.vec_z);
      tx = half_up(-(vy * qz - vz * qy) + qw * vx);
      ty = half_up(-(vz * qx - vx * qz) + qw * vy);
      tz = half_up(-(vx * qy - vy * qx) + qw * vz);
      tw = half_up(vx * qx + vy * qy + vz * qz);
      rx = half_up((qy * tz - qz * ty) + qw * tx + tw * qx);
      ry = half_up((qz * tx - qx * tz) + qw * ty + tw * qy);
      rz = half_up((qx * ty - qy * tx) + qw * tz + tw * qz);
      clip = 1'b0;
      res.rot_x   = clamp16(rx, clip);
      res.rot_y   = clamp16(ry, clip);
      res.rot_z   = clamp16(rz, clip);
      res.clipped = clip;
      return res;
    endfunction

    function void note_vector(in_item_t v);
      expected_rotations.push_back(rotate(v));
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        failures++;
        $display("%0t: %s expected %0d actual %0d", $realtime, name, exp_val, act_val);
      end
    endfunction

    function void check_rotation(out_item_t got);
      out_item_t want;
      if (expected_rotations.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none actual %h", $realtime, got);
        return;
      end
      want = expected_rotations.pop_front();
      compare_field("rot_x", $signed(want.rot_x), $signed(got.rot_x));
      compare_field("rot_y", $signed(want.rot_y), $signed(got.rot_y));
      compare_field("rot_z", $signed(want.rot_z), $signed(got.rot_z));
      compare_field("clipped", want.clipped, got.clipped);
    endfunction

    function int pending();
      return expected_rotations.size();
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PER_PHASE = 160;
  localparam int NUM_PHASES = 9;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;

  logic              calm = 1'b0;
  int                quiet_cycles = 0;

  rotation_scoreboard sb = new();

  quaternion_vector_rotate_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(99) < 13);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_rotation(out_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("quaternion_vector_rotate_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_quat_reg(input logic [1:0] idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= {{16{val[15]}}, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_component(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_quat(input logic [15:0] qx, qy, qz, qw);
    write_quat_reg(REG_QUAT_X, qx);
    write_quat_reg(REG_QUAT_Y, qy);
    write_quat_reg(REG_QUAT_Z, qz);
    write_quat_reg(REG_QUAT_W, qw);
  endtask

  task automatic send_vector(input in_item_t v);
    while (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      in_data  <= in_item_t'({$urandom, $urandom});
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    do @(posedge clk); while (in_stall);
    sb.note_vector(v);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_component();
    case ($urandom_range(15))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic load_unit_quat();
    real a[4];
    real norm;
    logic [15:0] q[4];
    norm = 0.0;
    for (int i = 0; i < 4; i++) begin
      a[i] = real'(int'($urandom_range(65535)) - 32768);
      norm += a[i] * a[i];
    end
    norm = $sqrt(norm);
    if (norm < 1.0) begin
      a[3] = 1.0;
      norm = 1.0;
    end
    for (int i = 0; i < 4; i++) begin
      q[i] = 16'($rtoi(a[i] * 32767.0 / norm));
    end
    load_quat(q[0], q[1], q[2], q[3]);
  endtask

  in_item_t corner_vectors[12];

  initial begin
    rst_n    <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    in_valid <= 1'b0;
    in_data  <= '0;
    corner_vectors = '{
      '{16'sd0, 16'sd0, 16'sd0},
      '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
      '{16'sh8000, 16'sh8000, 16'sh8000},
      '{16'sh7FFF, 16'sh8000, 16'sd0},
      '{16'sh8000, 16'sh7FFF, -16'sd1},
      '{16'sd1, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd1, 16'sd0},
      '{16'sd0, 16'sd0, 16'sd1},
      '{-16'sd1, -16'sd1, -16'sd1},
      '{16'sd12345, -16'sd23456, 16'sd30000},
      '{16'sh5555, 16'shAAAA, 16'sh5555},
      '{16'shAAAA, 16'sh5555, 16'shAAAA}
    };
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        1: load_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        2: load_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        3: load_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        4: load_quat(16'h0000, 16'h0000, 16'h0000, 16'h8000);
        5: load_quat(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
        6: load_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        7, 8: load_unit_quat();
        default: ;
      endcase
      if (phase < 2) begin
        foreach (corner_vectors[i]) send_vector(corner_vectors[i]);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        calm <= (phase == 6) && (n < 120);
        send_vector('{pick_component(), pick_component(), pick_component()});
      end
      calm <= 1'b0;
      drain();
    end

    repeat (20) @(negedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("quaternion_vector_rotate_unit regression: pass");
    end else begin
      $display("quaternion_vector_rotate_unit regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
